// ===== rtl/tclp_pkg.sv =====
// Shared types and constants for the text command line parser.
package tclp_pkg;

    localparam int LINE_MAX_DEF = 32;
    localparam int NUMBER_CHARS = 8;
    localparam int KW_COUNT     = 6;
    localparam int NUM_START    = 7;
    localparam int SCALE_POS    = 6;
    localparam int VAL_W        = 27;

    localparam logic [VAL_W-1:0] ACC_MAX = {VAL_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_OFF,
        CMD_START,
        CMD_STOP,
        CMD_LOG,
        CMD_SCALE,
        CMD_PERIOD
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_SCALE,
        ERR_PERIOD,
        ERR_LONG
    } err_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // keyword text, left aligned, character p at bits [63-8p -: 8]
    localparam logic [KW_COUNT-1:0][63:0] KW_TEXT = {
        {"PERIOD=", 8'h00},
        {"SCALE=", 16'h0000},
        {"LOG", 40'h0},
        {"STOP", 32'h0},
        {"START", 24'h0},
        {"OFF", 40'h0}
    };

    localparam logic [KW_COUNT-1:0][2:0] KW_LEN = {3'd7, 3'd6, 3'd3, 3'd4, 3'd5, 3'd3};

    localparam logic [KW_COUNT-1:0] KW_EXACT = 6'b000111;

endpackage

// ===== rtl/tclp_in_if.sv =====
// Byte channel into the parser.
interface tclp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/tclp_out_if.sv =====
// Result channel out of the parser.
interface tclp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command_kind;
    logic [1:0]  error_code;
    logic        reporting_on;
    logic        unit_fahrenheit;
    logic [26:0] interval_seconds;

    modport source (output valid, output command_kind, output error_code,
                    output reporting_on, output unit_fahrenheit,
                    output interval_seconds, input ready);
    modport sink (input valid, input command_kind, input error_code,
                  input reporting_on, input unit_fahrenheit,
                  input interval_seconds, output ready);
endinterface

// ===== rtl/text_command_line_parser.sv =====
// Latency: a result is valid in the cycle after the newline transfer.
// Throughput: one byte per cycle; each byte is matched as it arrives.
// The input stalls only while a result waits in the output register.
// Reset (rst_n, asynchronous, active low) clears the line state and sets
// reporting on, Fahrenheit and an interval of one second.
// Top level of the text command line parser.
module text_command_line_parser
    import tclp_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tclp_in_if.sink    byte_ch,
    tclp_out_if.source result_ch
);

    localparam int ColW = $clog2(LINE_MAX);

    logic [ColW-1:0]     col_reg, col_next;
    logic [ColW-1:0]     tlen_reg, tlen_next;
    logic                ended_reg, ended_next;
    logic [KW_COUNT-1:0] cand_reg, cand_next;
    logic [7:0]          scale_reg, scale_next;
    logic [VAL_W-1:0]    acc_reg, acc_next;
    radix_t              radix_reg, radix_next;
    phase_t              phase_reg, phase_next;
    logic                inval_reg, inval_next;
    logic                ovf_reg, ovf_next;
    logic                rep_reg, rep_next;
    logic                fahr_reg, fahr_next;
    logic [VAL_W-1:0]    ival_reg, ival_next;

    logic                ov_reg, ov_next;
    cmd_t                kind_o_reg;
    err_t                err_o_reg;
    logic                rep_o_reg;
    logic                fahr_o_reg;
    logic [VAL_W-1:0]    ival_o_reg;

    logic                accept;
    logic                is_nl;
    logic [7:0]          c;
    logic [ColW-1:0]     len;
    cmd_t                kind_new;
    err_t                err_new;
    logic                found;
    logic [4:0]          d;
    logic [4:0]          base;
    logic                in_num;

    function automatic logic [4:0] digit_value(input logic [7:0] ch);
        logic [4:0] v;
        v = 5'd16;
        if (ch >= "0" && ch <= "9") v = 5'(ch - "0");
        else if (ch >= "a" && ch <= "f") v = 5'(ch - "a" + 8'd10);
        else if (ch >= "A" && ch <= "F") v = 5'(ch - "A" + 8'd10);
        return v;
    endfunction

    // acc * base + digit, saturated to the field width
    function automatic logic [VAL_W-1:0] acc_step(input logic [VAL_W-1:0] acc,
                                                  input logic [3:0] dig,
                                                  input radix_t rdx);
        logic [VAL_W+4:0] prod;
        logic [VAL_W+4:0] sum;
        case (rdx)
            RADIX_HEX: prod = {1'b0, acc, 4'b0000};
            RADIX_OCT: prod = {2'b00, acc, 3'b000};
            default:   prod = {2'b00, acc, 3'b000} + {4'b0000, acc, 1'b0};
        endcase
        sum = prod + (VAL_W+5)'(dig);
        if (sum > (VAL_W+5)'(ACC_MAX)) return ACC_MAX;
        return sum[VAL_W-1:0];
    endfunction

    assign accept = byte_ch.valid && byte_ch.ready;
    assign c      = byte_ch.rx_byte;
    assign is_nl  = (c == 8'd10);
    assign len    = ended_reg ? tlen_reg : col_reg;
    assign d      = digit_value(c);
    assign base   = (radix_reg == RADIX_HEX) ? 5'd16 :
                    ((radix_reg == RADIX_OCT) ? 5'd8 : 5'd10);
    assign in_num = (int'(col_reg) >= NUM_START) &&
                    (int'(col_reg) < NUM_START + NUMBER_CHARS);

    assign byte_ch.ready = !ov_reg || result_ch.ready;

    always_comb
    begin
        col_next   = col_reg;
        tlen_next  = tlen_reg;
        ended_next = ended_reg;
        cand_next  = cand_reg;
        scale_next = scale_reg;
        acc_next   = acc_reg;
        radix_next = radix_reg;
        phase_next = phase_reg;
        inval_next = inval_reg;
        ovf_next   = ovf_reg;
        rep_next   = rep_reg;
        fahr_next  = fahr_reg;
        ival_next  = ival_reg;
        ov_next    = result_ch.ready ? 1'b0 : ov_reg;
        kind_new   = CMD_NONE;
        err_new    = ERR_NONE;
        found      = 1'b0;

        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (!found && cand_reg[i] &&
                (KW_EXACT[i] ? (len == ColW'(KW_LEN[i])) : (len >= ColW'(KW_LEN[i]))))
            begin
                found    = 1'b1;
                kind_new = cmd_t'(3'(i + 1));
            end
        end
        if (ovf_reg)
        begin
            kind_new = CMD_NONE;
            err_new  = ERR_LONG;
        end

        if (accept)
        begin
            if (!is_nl)
            begin
                if (int'(col_reg) >= LINE_MAX - 1)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    if (!ended_reg)
                    begin
                        if (c == 8'd0)
                        begin
                            ended_next = 1'b1;
                            tlen_next  = col_reg;
                        end
                        else
                        begin
                            for (int i = 0; i < KW_COUNT; i++)
                            begin
                                if (int'(col_reg) < int'(KW_LEN[i]))
                                begin
                                    if (c != KW_TEXT[i][8*(7-int'(col_reg[2:0])) +: 8])
                                        cand_next[i] = 1'b0;
                                end
                                else if (KW_EXACT[i])
                                begin
                                    cand_next[i] = 1'b0;
                                end
                            end
                            if (int'(col_reg) == SCALE_POS)
                                scale_next = c;
                            if (in_num)
                            begin
                                unique case (phase_reg)
                                    PH_START:
                                    begin
                                        if (c == " " || c == 8'd9 || c == 8'd11 ||
                                            c == 8'd12 || c == 8'd13)
                                        begin
                                            phase_next = PH_START;
                                        end
                                        else if (c == "+" || c == "-")
                                        begin
                                            inval_next = 1'b1;
                                            phase_next = PH_DONE;
                                        end
                                        else if (c == "0")
                                        begin
                                            radix_next = RADIX_OCT;
                                            phase_next = PH_ZERO;
                                        end
                                        else if (c >= "1" && c <= "9")
                                        begin
                                            radix_next = RADIX_DEC;
                                            acc_next   = VAL_W'(d);
                                            phase_next = PH_DIGITS;
                                        end
                                        else
                                        begin
                                            phase_next = PH_DONE;
                                        end
                                    end
                                    PH_ZERO:
                                    begin
                                        if (c == "x" || c == "X")
                                        begin
                                            radix_next = RADIX_HEX;
                                            phase_next = PH_PREFIX;
                                        end
                                        else if (c >= "0" && c <= "7")
                                        begin
                                            acc_next   = acc_step(acc_reg, d[3:0], RADIX_OCT);
                                            phase_next = PH_DIGITS;
                                        end
                                        else
                                        begin
                                            phase_next = PH_DONE;
                                        end
                                    end
                                    PH_PREFIX:
                                    begin
                                        if (d < 5'd16)
                                        begin
                                            acc_next   = acc_step(acc_reg, d[3:0], RADIX_HEX);
                                            phase_next = PH_DIGITS;
                                        end
                                        else
                                        begin
                                            phase_next = PH_DONE;
                                        end
                                    end
                                    PH_DIGITS:
                                    begin
                                        if (d < base)
                                            acc_next = acc_step(acc_reg, d[3:0], radix_reg);
                                        else
                                            phase_next = PH_DONE;
                                    end
                                    default:
                                    begin
                                        phase_next = phase_reg;
                                    end
                                endcase
                            end
                        end
                    end
                    col_next = col_reg + 1'b1;
                end
            end
            else
            begin
                case (kind_new)
                    CMD_START: rep_next = 1'b1;
                    CMD_STOP:  rep_next = 1'b0;
                    CMD_SCALE:
                    begin
                        if (scale_reg == "F") fahr_next = 1'b1;
                        else if (scale_reg == "C") fahr_next = 1'b0;
                        else err_new = ERR_SCALE;
                    end
                    CMD_PERIOD:
                    begin
                        if (inval_reg || acc_reg == '0) err_new = ERR_PERIOD;
                        else ival_next = acc_reg;
                    end
                    default: ;
                endcase
                ov_next    = 1'b1;
                col_next   = '0;
                tlen_next  = '0;
                ended_next = 1'b0;
                cand_next  = '1;
                scale_next = '0;
                acc_next   = '0;
                radix_next = RADIX_DEC;
                phase_next = PH_START;
                inval_next = 1'b0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            tlen_reg  <= '0;
            ended_reg <= 1'b0;
            cand_reg  <= '1;
            scale_reg <= '0;
            acc_reg   <= '0;
            radix_reg <= RADIX_DEC;
            phase_reg <= PH_START;
            inval_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            rep_reg   <= 1'b1;
            fahr_reg  <= 1'b1;
            ival_reg  <= VAL_W'(1);
            ov_reg    <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            tlen_reg  <= tlen_next;
            ended_reg <= ended_next;
            cand_reg  <= cand_next;
            scale_reg <= scale_next;
            acc_reg   <= acc_next;
            radix_reg <= radix_next;
            phase_reg <= phase_next;
            inval_reg <= inval_next;
            ovf_reg   <= ovf_next;
            rep_reg   <= rep_next;
            fahr_reg  <= fahr_next;
            ival_reg  <= ival_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_nl)
        begin
            kind_o_reg <= kind_new;
            err_o_reg  <= err_new;
            rep_o_reg  <= rep_next;
            fahr_o_reg <= fahr_next;
            ival_o_reg <= ival_next;
        end
    end

    assign result_ch.valid            = ov_reg;
    assign result_ch.command_kind     = kind_o_reg;
    assign result_ch.error_code       = err_o_reg;
    assign result_ch.reporting_on     = rep_o_reg;
    assign result_ch.unit_fahrenheit  = fahr_o_reg;
    assign result_ch.interval_seconds = ival_o_reg;

endmodule

// ===== rtl/tclp_checker.sv =====
// Port-level assertions for the parser, bound to the top level.
module tclp_checker
    import tclp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  in_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [1:0]  err,
    input logic [26:0] ival
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(err) && $stable(ival))
    else $error("result changed while stalled");

    // a result only follows a newline transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_byte == 8'd10))
    else $error("result without newline");

    // no input transfer while the output register is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output blocked");

    // error codes agree with the command
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (err != ERR_SCALE || kind == CMD_SCALE) &&
                      (err != ERR_PERIOD || kind == CMD_PERIOD) &&
                      (err != ERR_LONG || kind == CMD_NONE))
    else $error("error code inconsistent with command");

    // the interval never becomes zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ival != '0)
    else $error("zero interval reported");

endmodule

bind text_command_line_parser tclp_checker u_tclp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_ch.valid),
    .in_ready  (byte_ch.ready),
    .in_byte   (byte_ch.rx_byte),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .kind      (result_ch.command_kind),
    .err       (result_ch.error_code),
    .ival      (result_ch.interval_seconds)
);

// ===== sim/tb_text_command_line_parser.sv =====
// Testbench for text_command_line_parser: byte stream of command lines, checked per line result.
`timescale 1ns / 100ps

module tb_text_command_line_parser;
    import tclp_pkg::*;

    localparam int          LINE_LIMIT  = LINE_MAX_DEF;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          MAX_REPORTS = 10;
    localparam logic [7:0]  CH_NUL = 8'd0;
    localparam logic [7:0]  CH_TAB = 8'd9;
    localparam logic [7:0]  CH_NL  = 8'd10;
    localparam logic [7:0]  CH_VT  = 8'd11;
    localparam logic [7:0]  CH_FF  = 8'd12;
    localparam logic [7:0]  CH_CR  = 8'd13;

    typedef struct packed {
        cmd_t        kind;
        err_t        err;
        logic        rep;
        logic        fahr;
        logic [26:0] secs;
    } line_result_t;

    logic clk;
    logic rst_n;

    tclp_in_if  byte_if ();
    tclp_out_if res_if ();

    text_command_line_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_if.sink),
        .result_ch (res_if.source)
    );

    // parser state as the testbench sees it
    int          col;
    logic [5:0]  kw_alive;
    logic [7:0]  scale_chr;
    logic [26:0] num_val;
    radix_t      num_radix;
    phase_t      num_phase;
    logic        num_bad;
    logic        too_long;
    logic        text_done;
    int          text_cols;
    logic        rep_on;
    logic        fahr_on;
    logic [26:0] period_s;

    line_result_t expected_lines[$];
    logic [7:0]   line_buf[$];

    bit in_gaps_on;
    bit out_stalls_on;
    int quiet_cycles;
    int mismatches;
    int results_seen;
    int bytes_sent;
    int lines_sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] kw_word(input int k);
        case (k)
            0:       kw_word = {"OFF", 40'h0};
            1:       kw_word = {"START", 24'h0};
            2:       kw_word = {"STOP", 32'h0};
            3:       kw_word = {"LOG", 40'h0};
            4:       kw_word = {"SCALE=", 16'h0};
            default: kw_word = {"PERIOD=", 8'h0};
        endcase
    endfunction

    function automatic int kw_size(input int k);
        case (k)
            0:       kw_size = 3;
            1:       kw_size = 5;
            2:       kw_size = 4;
            3:       kw_size = 3;
            4:       kw_size = 6;
            default: kw_size = 7;
        endcase
    endfunction

    function automatic cmd_t kw_cmd(input int k);
        case (k)
            0:       kw_cmd = CMD_OFF;
            1:       kw_cmd = CMD_START;
            2:       kw_cmd = CMD_STOP;
            3:       kw_cmd = CMD_LOG;
            4:       kw_cmd = CMD_SCALE;
            default: kw_cmd = CMD_PERIOD;
        endcase
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            hex_digit = int'(c - "0");
        else if (c >= "a" && c <= "f")
            hex_digit = int'(c - "a") + 10;
        else if (c >= "A" && c <= "F")
            hex_digit = int'(c - "A") + 10;
        else
            hex_digit = 16;
    endfunction

    function automatic void clear_line();
        col       = 0;
        kw_alive  = '1;
        scale_chr = 8'h00;
        num_val   = '0;
        num_radix = RADIX_DEC;
        num_phase = PH_START;
        num_bad   = 1'b0;
        too_long  = 1'b0;
        text_done = 1'b0;
        text_cols = 0;
    endfunction

    function automatic void add_digit(input int d, input int base);
        logic [63:0] v;
        v = num_val * base + d;
        num_val = (v > ACC_MAX) ? ACC_MAX : v[26:0];
    endfunction

    // strtol-like number reader, base chosen by prefix
    function automatic void number_byte(input logic [7:0] c);
        int d;
        int base;
        d    = hex_digit(c);
        base = (num_radix == RADIX_HEX) ? 16 : ((num_radix == RADIX_OCT) ? 8 : 10);
        case (num_phase)
            PH_START:
                if (c == " " || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR)
                    num_phase = PH_START;
                else if (c == "+" || c == "-")
                begin
                    num_bad   = 1'b1;
                    num_phase = PH_DONE;
                end
                else if (c == "0")
                begin
                    num_radix = RADIX_OCT;
                    num_phase = PH_ZERO;
                end
                else if (c >= "1" && c <= "9")
                begin
                    num_radix = RADIX_DEC;
                    num_val   = 27'(d);
                    num_phase = PH_DIGITS;
                end
                else
                    num_phase = PH_DONE;
            PH_ZERO:
                if (c == "x" || c == "X")
                begin
                    num_radix = RADIX_HEX;
                    num_phase = PH_PREFIX;
                end
                else if (c >= "0" && c <= "7")
                begin
                    add_digit(d, 8);
                    num_phase = PH_DIGITS;
                end
                else
                    num_phase = PH_DONE;
            PH_PREFIX:
                if (d < 16)
                begin
                    add_digit(d, 16);
                    num_phase = PH_DIGITS;
                end
                else
                    num_phase = PH_DONE;
            PH_DIGITS:
                if (d < base)
                    add_digit(d, base);
                else
                    num_phase = PH_DONE;
            default:
                num_phase = PH_DONE;
        endcase
    endfunction

    function automatic void match_byte(input logic [7:0] c, input int p);
        logic [63:0] w;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            w = kw_word(k);
            if (p < kw_size(k))
            begin
                if (c != w[63-8*p -: 8])
                    kw_alive[k] = 1'b0;
            end
            else if (k < 3)
                kw_alive[k] = 1'b0;
        end
        if (p == SCALE_POS)
            scale_chr = c;
        if (p >= NUM_START && p - NUM_START < NUMBER_CHARS)
            number_byte(c);
    endfunction

    function automatic void predict_line_byte(input logic [7:0] c);
        line_result_t r;
        int           n;
        bit           found;
        if (c != CH_NL)
        begin
            if (col >= LINE_LIMIT - 1)
                too_long = 1'b1;
            else
            begin
                if (!text_done)
                begin
                    if (c == CH_NUL)
                    begin
                        text_done = 1'b1;
                        text_cols = col;
                    end
                    else
                        match_byte(c, col);
                end
                col++;
            end
        end
        else
        begin
            n      = text_done ? text_cols : col;
            r.kind = CMD_NONE;
            r.err  = ERR_NONE;
            found  = 0;
            if (too_long)
                r.err = ERR_LONG;
            else
            begin
                for (int k = 0; k < KW_COUNT; k++)
                    if (!found && kw_alive[k] &&
                        ((k < 3) ? (n == kw_size(k)) : (n >= kw_size(k))))
                    begin
                        r.kind = kw_cmd(k);
                        found  = 1;
                    end
                case (r.kind)
                    CMD_START: rep_on = 1'b1;
                    CMD_STOP:  rep_on = 1'b0;
                    CMD_SCALE:
                        if (scale_chr == "F")
                            fahr_on = 1'b1;
                        else if (scale_chr == "C")
                            fahr_on = 1'b0;
                        else
                            r.err = ERR_SCALE;
                    CMD_PERIOD:
                        if (num_bad || num_val == 0)
                            r.err = ERR_PERIOD;
                        else
                            period_s = num_val;
                    default: ;
                endcase
            end
            r.rep  = rep_on;
            r.fahr = fahr_on;
            r.secs = period_s;
            expected_lines.push_back(r);
            lines_sent++;
            clear_line();
        end
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_byte(input logic [7:0] b);
        if (in_gaps_on && $urandom_range(0, 5) == 0)
        begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.rx_byte <= b;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        predict_line_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        send_byte(CH_NL);
        line_buf.delete();
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void put_kw(input int k, input int n);
        logic [63:0] w;
        w = kw_word(k);
        for (int p = 0; p < n; p++)
            line_buf.push_back(w[63-8*p -: 8]);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= CH_NL)
            b = b + 1;
        return b;
    endfunction

    function automatic void put_noise(input int n);
        repeat (n)
            line_buf.push_back(noise_byte());
    endfunction

    function automatic void put_digits(input int n, input int base);
        int v;
        repeat (n)
        begin
            v = $urandom_range(0, base - 1);
            if (v < 10)
                line_buf.push_back(8'("0" + v));
            else
                line_buf.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + v - 10));
        end
    endfunction

    function automatic void put_blank();
        case ($urandom_range(0, 4))
            0:       line_buf.push_back(" ");
            1:       line_buf.push_back(CH_TAB);
            2:       line_buf.push_back(CH_VT);
            3:       line_buf.push_back(CH_FF);
            default: line_buf.push_back(CH_CR);
        endcase
    endfunction

    function automatic void put_number();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                put_blank();
        if ($urandom_range(0, 11) == 0)
            line_buf.push_back($urandom_range(0, 1) ? "+" : "-");
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                line_buf.push_back(8'("1" + $urandom_range(0, 8)));
                put_digits($urandom_range(0, 9), 10);
            end
            4, 5:
            begin
                line_buf.push_back("0");
                put_digits($urandom_range(0, 8), ($urandom_range(0, 3) == 0) ? 10 : 8);
            end
            6, 7:
            begin
                line_buf.push_back("0");
                line_buf.push_back($urandom_range(0, 1) ? "x" : "X");
                put_digits($urandom_range(0, 8), 16);
            end
            8:
                put_text($urandom_range(0, 1) ? "0" : "0x");
            default:
                put_noise($urandom_range(0, 4));
        endcase
        if ($urandom_range(0, 3) == 0)
            put_noise($urandom_range(1, 4));
    endfunction

    function automatic void build_random_line();
        int pick;
        int k;
        int n;
        pick = $urandom_range(0, 99);
        line_buf.delete();
        if (pick < 12)
        begin
            k = $urandom_range(0, 2);
            put_kw(k, kw_size(k));
        end
        else if (pick < 20)
        begin
            put_kw(3, 3);
            put_noise($urandom_range(0, 6));
        end
        else if (pick < 38)
        begin
            put_kw(4, 6);
            case ($urandom_range(0, 5))
                0, 1:    line_buf.push_back("F");
                2, 3:    line_buf.push_back("C");
                4:       line_buf.push_back($urandom_range(0, 1) ? "f" : "c");
                default: if ($urandom_range(0, 1)) line_buf.push_back(noise_byte());
            endcase
            if ($urandom_range(0, 3) == 0)
                put_noise($urandom_range(1, 4));
        end
        else if (pick < 72)
        begin
            put_kw(5, 7);
            put_number();
        end
        else if (pick < 80)
        begin
            // keyword with one byte spoiled
            k = $urandom_range(0, 5);
            put_kw(k, kw_size(k));
            line_buf[$urandom_range(0, kw_size(k) - 1)] = noise_byte();
            if (k >= 4)
                line_buf.push_back((k == 4) ? "C" : "5");
        end
        else if (pick < 86)
            put_noise($urandom_range(0, 12));
        else if (pick < 91)
        begin
            k = $urandom_range(0, 5);
            n = $urandom_range(28, 44);
            put_kw(k, kw_size(k));
            while (line_buf.size() < n)
                line_buf.push_back(noise_byte());
        end
        else if (pick < 96)
        begin
            // text cut short by a NUL byte
            k = $urandom_range(0, 5);
            if (k == 5 && $urandom_range(0, 1))
            begin
                put_kw(5, 7);
                put_number();
            end
            else
                put_kw(k, $urandom_range(0, kw_size(k)));
            line_buf.push_back(CH_NUL);
            put_noise($urandom_range(0, 8));
        end
    endfunction

    task automatic test_directed_lines();
        send_line();
        put_text("OFF");            send_line();
        put_text("STOP");           send_line();
        put_text("START");          send_line();
        put_text("LOG");            send_line();
        put_text("LOG rest");       send_line();
        put_text("OFFX");           send_line();
        put_text("STAR");           send_line();
        put_text("SCALE=C");        send_line();
        put_text("SCALE=F");        send_line();
        put_text("SCALE=q");        send_line();
        put_text("SCALE=");         send_line();
        put_text("PERIOD=42");      send_line();
        put_text("PERIOD=0x1aF");   send_line();
        put_text("PERIOD=017");     send_line();
        put_text("PERIOD=0");       send_line();
        put_text("PERIOD=0x");      send_line();
        put_text("PERIOD=-5");      send_line();
        put_text("PERIOD=+5");      send_line();
        put_text("PERIOD=abc");     send_line();
        put_text("PERIOD= ");
        line_buf.push_back(CH_TAB);
        line_buf.push_back(CH_VT);
        line_buf.push_back(CH_FF);
        line_buf.push_back(CH_CR);
        put_text("9");              send_line();
        put_text("PERIOD=123456789"); send_line();
        put_text("PERIOD=0xFFFFFF"); send_line();
        put_text("OFF");
        line_buf.push_back(CH_NUL);
        put_text("junk");           send_line();
        line_buf.push_back(CH_NUL);
        put_text("STOP");           send_line();
        // 31 bytes still fit, 32 do not
        put_text("LOG");
        repeat (28) line_buf.push_back("z");
        send_line();
        put_text("STOP");
        line_buf.push_back(8'hFF);
        repeat (27) line_buf.push_back("q");
        send_line();
        put_text("SCALE=C");
        repeat (40) line_buf.push_back(8'hFF);
        send_line();
    endtask

    task automatic test_random_lines(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            build_random_line();
            send_line();
        end
    endtask

    task automatic test_pause_for_results();
        repeat (4)
        begin
            repeat ($urandom_range(1, 4))
            begin
                build_random_line();
                send_line();
            end
            byte_if.valid <= 1'b0;
            @(negedge clk);
            while (expected_lines.size() != 0)
                @(negedge clk);
        end
    endtask

    task automatic test_back_to_back(input int n_bytes);
        in_gaps_on    = 0;
        out_stalls_on = 0;
        test_random_lines(n_bytes);
    endtask

    initial
    begin : result_sink
        int stall_left;
        res_if.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (out_stalls_on && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    initial
    begin : result_check
        line_result_t want;
        line_result_t got;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (rst_n && res_if.valid && res_if.ready)
            begin
                results_seen++;
                got.kind = cmd_t'(res_if.command_kind);
                got.err  = err_t'(res_if.error_code);
                got.rep  = res_if.reporting_on;
                got.fahr = res_if.unit_fahrenheit;
                got.secs = res_if.interval_seconds;
                if (expected_lines.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result %0d: kind %0d err %0d rep %0b fahr %0b secs %0d",
                                 results_seen, got.kind, got.err, got.rep, got.fahr, got.secs);
                end
                else
                begin
                    want = expected_lines.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("result %0d: exp kind %0d err %0d rep %0b fahr %0b secs %0d",
                                     results_seen, want.kind, want.err, want.rep, want.fahr,
                                     want.secs);
                            $display("result %0d: got kind %0d err %0d rep %0b fahr %0b secs %0d",
                                     results_seen, got.kind, got.err, got.rep, got.fahr,
                                     got.secs);
                        end
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, expected_lines.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        byte_if.valid   = 1'b0;
        byte_if.rx_byte = 8'h00;
        in_gaps_on      = 1;
        out_stalls_on   = 1;
        mismatches      = 0;
        results_seen    = 0;
        bytes_sent      = 0;
        lines_sent      = 0;
        clear_line();
        rep_on   = 1'b1;
        fahr_on  = 1'b1;
        period_s = 27'd1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_lines();
        test_random_lines(760);
        test_pause_for_results();
        test_back_to_back(220);

        byte_if.valid <= 1'b0;
        @(negedge clk);
        while (expected_lines.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("run: %0d bytes in %0d lines, %0d results checked, %0d mismatches",
                 bytes_sent, lines_sent, results_seen, mismatches);
        $display("run: keywords, scale letters, period radices, NUL cut and over-long lines");
        if (expected_lines.size() != 0)
            $display("%0d results never arrived", expected_lines.size());
        if (mismatches == 0 && expected_lines.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
